// File: rtl/core/jsu_pkg.sv
package jsu_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_CLOSED = 2'd1,
        KIND_UNTERM = 2'd2
    } t_kind;

    // source characters with a special meaning
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;

    // utf-8 encoding constants
    localparam logic [15:0] UTF8_LIMIT1 = 16'h0080;
    localparam logic [15:0] UTF8_LIMIT2 = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [5:0]  UTF8_MASK   = 6'h3F;

    // all results caused by one input byte: data bytes, then an optional marker
    typedef struct packed {
        logic [1:0]      nbytes;
        logic [2:0][7:0] data;
        logic            has_tail;
        logic            tail_err;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef struct packed {
        logic idle;
    } t_front_stat;

endpackage

// File: rtl/core/jsu_in_if.sv
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// File: rtl/core/jsu_out_if.sv
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// File: rtl/core/jsu_queue.sv
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_group      i_data,
    input  logic        i_pop,
    output t_group      o_head,
    output t_queue_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group         r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/core/jsu_front.sv
module jsu_front
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    jsu_in_if.sink      i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_group      o_group,
    output t_front_stat o_stat
);

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_HEX   = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_hex_accum, n_hex_accum;
    logic        r_hex_stopped, n_hex_stopped;

    logic        accept;
    logic [7:0]  b;
    logic        eoi;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] acc_step;
    logic        closed;
    t_group      grp;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign eoi        = i_in.end_of_input;

    // hex digit decode
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hex_val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hex_val = 4'(b - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_step = (!r_hex_stopped && hex_ok) ? {r_hex_accum[11:0], hex_val} : r_hex_accum;

    always_comb begin
        n_phase       = r_phase;
        n_hex_count   = r_hex_count;
        n_hex_accum   = r_hex_accum;
        n_hex_stopped = r_hex_stopped;
        grp           = '0;
        closed        = 1'b0;

        unique case (r_phase)
            PH_ESC: begin
                n_phase = PH_PLAIN;
                if (b == CH_U) begin
                    n_phase       = PH_HEX;
                    n_hex_count   = '0;
                    n_hex_accum   = '0;
                    n_hex_stopped = 1'b0;
                end else begin
                    grp.nbytes = 2'd1;
                    unique case (b)
                        CH_N:    grp.data[0] = 8'h0A;
                        CH_T:    grp.data[0] = 8'h09;
                        CH_R:    grp.data[0] = 8'h0D;
                        CH_B:    grp.data[0] = 8'h08;
                        CH_F:    grp.data[0] = 8'h0C;
                        default: grp.data[0] = b;
                    endcase
                end
            end
            PH_HEX: begin
                n_hex_accum   = acc_step;
                n_hex_stopped = r_hex_stopped || !hex_ok;
                n_hex_count   = r_hex_count + 2'd1;
                if (r_hex_count == 2'd3) begin
                    if (acc_step < UTF8_LIMIT1) begin
                        grp.nbytes  = 2'd1;
                        grp.data[0] = acc_step[7:0];
                    end else if (acc_step < UTF8_LIMIT2) begin
                        grp.nbytes  = 2'd2;
                        grp.data[0] = UTF8_LEAD2 | {3'd0, acc_step[10:6]};
                        grp.data[1] = UTF8_CONT | {2'd0, acc_step[5:0] & UTF8_MASK};
                    end else begin
                        grp.nbytes  = 2'd3;
                        grp.data[0] = UTF8_LEAD3 | {4'd0, acc_step[15:12]};
                        grp.data[1] = UTF8_CONT | {2'd0, acc_step[11:6] & UTF8_MASK};
                        grp.data[2] = UTF8_CONT | {2'd0, acc_step[5:0] & UTF8_MASK};
                    end
                    n_phase       = PH_PLAIN;
                    n_hex_count   = '0;
                    n_hex_accum   = '0;
                    n_hex_stopped = 1'b0;
                end
            end
            default: begin
                if (b == CH_QUOTE) begin
                    grp.has_tail  = 1'b1;
                    grp.tail_err  = 1'b0;
                    closed        = 1'b1;
                    n_phase       = PH_PLAIN;
                    n_hex_count   = '0;
                    n_hex_accum   = '0;
                    n_hex_stopped = 1'b0;
                end else if (b == CH_BACKSLASH && !eoi) begin
                    n_phase = PH_ESC;
                end else begin
                    grp.nbytes  = 2'd1;
                    grp.data[0] = b;
                end
            end
        endcase

        // end of input without a closing quote
        if (eoi && !closed) begin
            grp.has_tail  = 1'b1;
            grp.tail_err  = 1'b1;
            n_phase       = PH_PLAIN;
            n_hex_count   = '0;
            n_hex_accum   = '0;
            n_hex_stopped = 1'b0;
        end
    end

    assign o_group     = grp;
    assign o_push      = accept && (grp.nbytes != 2'd0 || grp.has_tail);
    assign o_stat.idle = (r_phase == PH_PLAIN) && (r_hex_count == '0)
                         && (r_hex_accum == '0) && !r_hex_stopped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_PLAIN;
            r_hex_count   <= '0;
            r_hex_accum   <= '0;
            r_hex_stopped <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_hex_count   <= n_hex_count;
            r_hex_accum   <= n_hex_accum;
            r_hex_stopped <= n_hex_stopped;
        end
    end

endmodule

// File: rtl/core/jsu_back.sv
module jsu_back
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_group      i_head,
    input  t_queue_stat i_q_stat,
    output logic        o_pop,
    jsu_out_if.source   o_out
);

    logic        r_valid;
    t_kind       r_kind;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [1:0]  r_idx;

    logic [2:0]  total;
    logic        beat_last;
    t_kind       beat_kind;
    logic [7:0]  beat_byte;
    logic        load;

    assign total     = {1'b0, i_head.nbytes} + {2'd0, i_head.has_tail};
    assign beat_last = ({1'b0, r_idx} + 3'd1 == total);

    // pick the beat at the current index of the head group
    always_comb begin
        beat_kind = KIND_BYTE;
        beat_byte = 8'h00;
        if (r_idx < i_head.nbytes) begin
            case (r_idx)
                2'd0:    beat_byte = i_head.data[0];
                2'd1:    beat_byte = i_head.data[1];
                default: beat_byte = i_head.data[2];
            endcase
        end else begin
            beat_kind = i_head.tail_err ? KIND_UNTERM : KIND_CLOSED;
        end
    end

    assign load  = !i_q_stat.empty && (!r_valid || o_out.ready);
    assign o_pop = load && beat_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= beat_last ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= beat_kind;
            r_byte <= beat_byte;
            r_last <= beat_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.kind     = r_kind;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

endmodule

// File: rtl/core/json_string_unescape_unit.sv
// streaming unescaper for the body of a json string: one source byte per input beat,
// decoded bytes, a closed marker or an unterminated marker per output beat, with last set
// on the final beat caused by each source byte. a source byte is taken every cycle as long
// as the group queue has room; each output beat passes through the output register, so
// a unicode escape that finishes with three utf-8 bytes (plus an unterminated marker if the
// input ends there) holds the output side for up to four beats while the front keeps
// filling the queue of QUEUE_DEPTH groups. a byte that yields results shows its first beat
// after the group queue and the output register; bytes that yield nothing (a backslash,
// \u and its first three digits) leave no trace on the output. the front keeps the escape
// state, so a byte right behind its predecessor is decoded with the state already updated
module json_string_unescape_unit
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    // front to queue
    logic        push;
    t_group      push_group;
    t_front_stat f_stat;

    // queue to back
    t_group      head;
    t_queue_stat q_stat;
    logic        pop;

    // front: escape state machine, builds one result group per source byte
    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_group  (push_group),
        .o_stat   (f_stat)
    );

    // queue of pending result groups, decouples input and output stalls
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_group),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // back: splits the head group into beats through the output register
    jsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // a group handed over by the front is never dropped
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_stat.empty)
        else $error("pushed group missing from queue");

    // end of input always leaves the escape state cleared
    a_eoi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.end_of_input) |=> f_stat.idle)
        else $error("escape state not cleared after end of input");

    // a marker is always the final beat of its group
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != KIND_BYTE) |-> (o_out.last && o_out.out_byte == 8'h00))
        else $error("marker beat not last or carries data");

    // queue status is consistent
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

endmodule

// File: test/json_string_unescape_unit_test.sv
`timescale 1ns / 1ps

import jsu_pkg::*;

// one output beat as the block should present it
typedef struct packed {
    t_kind      kind;
    logic [7:0] data;
    logic       last;
} t_out_beat;

// tracks the escape state of the string body and queues the beats each source byte must cause
class unescape_scoreboard;
    typedef enum logic [2:0] {
        PH_PLAIN  = 3'd0,
        PH_ESCAPE = 3'd1,
        PH_HEX    = 3'd2
    } t_phase;

    t_out_beat   expected_beats[$];
    t_phase      phase;
    logic [2:0]  digits_taken;
    logic [15:0] code_unit;
    logic        digits_stopped;
    int          mismatches;
    int          beats_seen;
    int          closed_seen;
    int          unterm_seen;

    function new();
        clear_escape();
    endfunction

    function void clear_escape();
        phase          = PH_PLAIN;
        digits_taken   = 3'd0;
        code_unit      = 16'h0000;
        digits_stopped = 1'b0;
    endfunction

    function int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function void push_beat(input t_kind k, input logic [7:0] d);
        expected_beats.push_back('{kind: k, data: d, last: 1'b0});
    endfunction

    // works out the beats caused by one accepted source byte
    function void predict_source_byte(input logic [7:0] b, input logic eoi);
        int         v;
        int         queued;
        logic       closed;
        logic [7:0] c;
        queued = expected_beats.size();
        closed = 1'b0;
        case (phase)
            PH_ESCAPE: begin
                phase = PH_PLAIN;
                if (b == CH_U) begin
                    clear_escape();
                    phase = PH_HEX;
                end else begin
                    case (b)
                        CH_N:    c = 8'h0A;
                        CH_T:    c = 8'h09;
                        CH_R:    c = 8'h0D;
                        CH_B:    c = 8'h08;
                        CH_F:    c = 8'h0C;
                        default: c = b;
                    endcase
                    push_beat(KIND_BYTE, c);
                end
            end
            PH_HEX: begin
                v = hex_digit(b);
                // once a non-hex byte shows up, the rest of the four add nothing
                if (!digits_stopped && v >= 0) begin
                    code_unit = {code_unit[11:0], v[3:0]};
                end else begin
                    digits_stopped = 1'b1;
                end
                digits_taken = digits_taken + 3'd1;
                if (digits_taken >= 3'd4) begin
                    if (code_unit < UTF8_LIMIT1) begin
                        push_beat(KIND_BYTE, code_unit[7:0]);
                    end else if (code_unit < UTF8_LIMIT2) begin
                        push_beat(KIND_BYTE, UTF8_LEAD2 | {3'b000, code_unit[10:6]});
                        push_beat(KIND_BYTE, UTF8_CONT | {2'b00, code_unit[5:0] & UTF8_MASK});
                    end else begin
                        push_beat(KIND_BYTE, UTF8_LEAD3 | {4'h0, code_unit[15:12]});
                        push_beat(KIND_BYTE, UTF8_CONT | {2'b00, code_unit[11:6] & UTF8_MASK});
                        push_beat(KIND_BYTE, UTF8_CONT | {2'b00, code_unit[5:0] & UTF8_MASK});
                    end
                    clear_escape();
                end
            end
            default: begin
                if (b == CH_QUOTE) begin
                    push_beat(KIND_CLOSED, 8'h00);
                    clear_escape();
                    closed = 1'b1;
                end else if (b == CH_BACKSLASH && !eoi) begin
                    phase = PH_ESCAPE;
                end else begin
                    push_beat(KIND_BYTE, b);
                end
            end
        endcase
        if (eoi && !closed) begin
            push_beat(KIND_UNTERM, 8'h00);
            clear_escape();
        end
        if (expected_beats.size() > queued) begin
            expected_beats[expected_beats.size() - 1].last = 1'b1;
        end
    endfunction

    function void report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // compares one accepted output beat with the oldest expected one
    function void compare_output_beat(input logic [1:0] kind, input logic [7:0] data,
                                      input logic last);
        t_out_beat want;
        beats_seen++;
        if (kind == KIND_CLOSED) closed_seen++;
        if (kind == KIND_UNTERM) unterm_seen++;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d byte %02h last %0b",
                                      kind, data, last));
            return;
        end
        want = expected_beats.pop_front();
        if (kind !== want.kind || data !== want.data || last !== want.last) begin
            report_mismatch($sformatf(
                "beat %0d: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
                beats_seen, want.kind, want.data, want.last, kind, data, last));
        end
    endfunction

    function void check_leftovers();
        if (expected_beats.size() != 0) begin
            report_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));
        end
    endfunction
endclass

module json_string_unescape_unit_test;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam int         RANDOM_BYTES = 420;
    localparam int         HOLD_CYCLES  = 80;
    // margin for the output register and the group queue to drain
    localparam int         DRAIN_CYCLES = 32;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    unescape_scoreboard decode_sb = new();

    int items_sent;
    int hold_offs;
    bit hold_off;   // receiver held off for a long stretch
    bit send_calm;  // sender runs back to back
    bit recv_calm;  // receiver takes every beat at once

    json_string_unescape_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always #4 i_clk = ~i_clk;

    // ascii hex digit, letters in either case
    function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
        if (d < 4'd10) return 8'h30 + d;
        return (upper ? 8'h41 : 8'h61) + d - 8'd10;
    endfunction

    // code units spread over the one, two and three byte utf-8 ranges, surrogates and edges
    function automatic logic [15:0] pick_code_unit();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            3: return 16'($urandom_range(16'hD800, 16'hDFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 16'h0000;
                    1:       return 16'h007F;
                    2:       return 16'h0080;
                    3:       return 16'h07FF;
                    4:       return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
        return 16'h0000;
    endfunction

    // offers one source beat after a random gap and waits for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        // keep pushing while the receiver is held off so the queue fills up
        gap = (send_calm || hold_off) ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.in_byte      <= b;
        in_if.end_of_input <= eoi;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        decode_sb.predict_source_byte(b, eoi);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic eoi_last);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_byte(s[i], eoi_last && (i == s.len() - 1));
        end
    endtask

    // backslash-u escape; eoi_pos 1 ends the input on the u, 2..5 on a digit, 0 never
    task automatic send_unicode(input logic [15:0] cp, input int eoi_pos);
        int         i;
        logic [3:0] nib;
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_U, eoi_pos == 1);
        for (i = 0; i < 4; i++) begin
            if (eoi_pos != 0 && i + 2 > eoi_pos) break;
            nib = 4'((cp >> (12 - 4 * i)) & 16'h000F);
            send_byte(hex_char(nib, 1'($urandom_range(0, 1))), eoi_pos == i + 2);
        end
    endtask

    // mostly well-formed string bodies with random content, some noise and broken escapes
    task automatic run_random();
        int         pick;
        int         target;
        int         i;
        logic [7:0] b;
        target = items_sent + RANDOM_BYTES;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // plain byte, any value but the two with a meaning
                do b = 8'($urandom_range(1, 255));
                while (b == CH_QUOTE || b == CH_BACKSLASH);
                send_byte(b, 1'b0);
            end else if (pick < 53) begin
                send_byte(CH_BACKSLASH, 1'b0);
                case ($urandom_range(0, 7))
                    0:       send_byte(CH_N, 1'b0);
                    1:       send_byte(CH_T, 1'b0);
                    2:       send_byte(CH_R, 1'b0);
                    3:       send_byte(CH_B, 1'b0);
                    4:       send_byte(CH_F, 1'b0);
                    5:       send_byte(CH_BACKSLASH, 1'b0);
                    6:       send_byte(CH_SLASH, 1'b0);
                    default: send_byte(CH_QUOTE, 1'b0);
                endcase
            end else if (pick < 58) begin
                // escape with a random byte other than u; an unknown one passes the byte through
                send_byte(CH_BACKSLASH, 1'b0);
                do b = 8'($urandom_range(1, 255));
                while (b == CH_U);
                send_byte(b, 1'b0);
            end else if (pick < 78) begin
                // now and then the input ends on the last digit: up to four beats
                send_unicode(pick_code_unit(), ($urandom_range(0, 7) == 0) ? 5 : 0);
            end else if (pick < 85) begin
                // broken unicode escape: digits mixed with arbitrary bytes
                send_byte(CH_BACKSLASH, 1'b0);
                send_byte(CH_U, 1'b0);
                for (i = 0; i < 4; i++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        b = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                    end else begin
                        b = 8'($urandom_range(1, 255));
                    end
                    send_byte(b, 1'b0);
                end
            end else if (pick < 93) begin
                send_byte(CH_QUOTE, 1'b0);
            end else if (pick < 97) begin
                case ($urandom_range(0, 3))
                    0:       send_byte(CH_BACKSLASH, 1'b1);
                    1:       send_byte(CH_QUOTE, 1'b1);
                    default: send_byte(8'($urandom_range(1, 255)), 1'b1);
                endcase
            end else begin
                // input ends inside a unicode escape
                send_unicode(pick_code_unit(), $urandom_range(1, 5));
            end
        end
    endtask

    // output side: random stalls per beat, plus the long hold-offs
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off || stall_left > 0) begin
                out_if.ready <= 1'b0;
                if (!hold_off) stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (out_if.ready === 1'b1 && out_if.valid === 1'b1) begin
                decode_sb.compare_output_beat(out_if.kind, out_if.out_byte, out_if.last);
                if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
                stall_left = recv_calm ? 0 : $urandom_range(0, 11);
            end
        end
    end

    // long receiver hold-offs, counted here, once early and once late in the random part
    initial begin : hold_off_ctrl
        hold_off = 1'b0;
        wait (items_sent >= 40);
        @(posedge i_clk);
        hold_off <= 1'b1;
        hold_offs++;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
        wait (items_sent >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        hold_offs++;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.in_byte       = 8'h00;
        in_if.end_of_input  = 1'b0;
        out_if.ready        = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, a simple and an unknown escape, one and three byte
        // unicode, a non-hex stop with a swallowed quote, a close, and a trailing backslash
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\\t\\x\\u0041\\uFFFF\\u7\"z9\"", 1'b0);
        send_byte(CH_BACKSLASH, 1'b1);

        run_random();

        @(negedge i_clk);
        in_if.valid <= 1'b0;

        while (decode_sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        decode_sb.check_leftovers();

        $display("sent %0d source bytes with %0d long output hold-offs",
                 items_sent, hold_offs);
        $display("checked %0d output beats: %0d closed and %0d unterminated markers",
                 decode_sb.beats_seen, decode_sb.closed_seen, decode_sb.unterm_seen);
        if (decode_sb.mismatches == 0) begin
            $display("json_string_unescape_unit_test: PASS");
        end else begin
            $display("%0d mismatches in total", decode_sb.mismatches);
            $display("json_string_unescape_unit_test: FAIL");
        end
        $finish;
    end

    // generous bound well beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("timeout with %0d beats still expected", decode_sb.expected_beats.size());
        $display("json_string_unescape_unit_test: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_in_if.sv
rtl/core/jsu_out_if.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_front.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_unit.sv
test/json_string_unescape_unit_test.sv
